### design/buck_boost_duty_law_top_macros.svh
// assertion macros shared by the duty law checker
`ifndef BUCK_BOOST_DUTY_LAW_TOP_MACROS_SVH
`define BUCK_BOOST_DUTY_LAW_TOP_MACROS_SVH

// antecedent implies consequent on the same edge
`define BBDL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("duty law check failed");

// condition must never be seen
`define BBDL_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("duty law forbidden condition seen");

`endif

### design/bbdl_pkg.sv
// types, constants and register map of the buck-boost duty law block
package bbdl_pkg;

    localparam int DUTY_W   = 16;
    localparam int PHASE_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int LAW_W    = 18;
    localparam int NUM_W    = 33;
    localparam int DIV_STAGES = LAW_W;
    // s1, s2, s3, divider bits, scale, compare, output
    localparam int PIPE_LATENCY = 3 + DIV_STAGES + 3;

    localparam int MAX_PHASES_DEF    = 8;
    localparam int SYMMETRIC_PWM_DEF = 1;

    localparam logic [16:0]      Q14_ONE = 17'd16384;
    localparam logic [LAW_W-1:0] LAW_SAT = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LAW_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_BASE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIXED_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_FLOOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_CEILING = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PHASES_ACTIVE = 3'd7;

    // law modes
    localparam logic [1:0] MODE_BUCK  = 2'd0;
    localparam logic [1:0] MODE_BOOST = 2'd1;

    // opcodes
    localparam logic OP_LAW    = 1'b0;
    localparam logic OP_DIRECT = 1'b1;

    // reset values
    localparam logic [1:0]        RST_LAW_MODE      = 2'd0;
    localparam logic [DUTY_W-1:0] RST_DUTY_BASE     = 16'd62915;
    localparam logic [DUTY_W-1:0] RST_MIXED_GAIN    = 16'd21627;
    localparam logic [DUTY_W-1:0] RST_RATIO_FLOOR   = 16'd11960;
    localparam logic [DUTY_W-1:0] RST_RATIO_CEILING = 16'd22446;
    localparam logic [DUTY_W-1:0] RST_DUTY_LIMIT    = 16'd63570;
    localparam logic [DUTY_W-1:0] RST_PERIOD_TICKS  = 16'd0;
    localparam logic [3:0]        RST_PHASES_ACTIVE = 4'd1;

    typedef struct packed {
        logic              opcode;
        logic [PHASE_W-1:0] phase_index;
        logic [DUTY_W-1:0] ratio;
        logic [DUTY_W-1:0] alpha;
        logic [DUTY_W-1:0] direct_duty;
    } duty_req_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_out;
        logic              accepted;
        logic [DUTY_W-1:0] duty_leg_a;
        logic [DUTY_W-1:0] duty_leg_b;
        logic [DUTY_W-1:0] rise_cmp_a;
        logic [DUTY_W-1:0] fall_cmp_a;
        logic [DUTY_W-1:0] rise_cmp_b;
        logic [DUTY_W-1:0] fall_cmp_b;
        logic              leg_b_updated;
        logic [DUTY_W-1:0] clamped_ratio;
    } duty_rsp_t;

    // one pipeline stage record
    typedef struct packed {
        logic              valid;
        logic              op;
        logic [PHASE_W-1:0] phase;
        logic              acc;
        logic [DUTY_W-1:0] alpha;
        logic [DUTY_W-1:0] direct;
        logic [DUTY_W-1:0] r;
        logic [LAW_W-1:0]  la;
        logic              lb_base;
        logic              lb_sat;
        logic [NUM_W-1:0]  num;
        logic [DUTY_W-1:0] rem;
        logic [LAW_W-1:0]  quo;
        logic [DUTY_W-1:0] da;
        logic [DUTY_W-1:0] db;
        logic [DUTY_W-1:0] rise_a;
        logic [DUTY_W-1:0] fall_a;
        logic [DUTY_W-1:0] rise_b;
        logic [DUTY_W-1:0] fall_b;
    } pipe_t;

endpackage

### design/buck_boost_duty_law_top.sv
// top level of the four-switch buck-boost duty law pipeline
//
// One duty update enters on every clock with start high; busy never rises, so
// transactions may be issued back to back without a gap. Each result appears
// on rsp with done high for one cycle, in order. The receiver cannot stall:
// it must take each result in the cycle it shows. The pipeline depth is set
// by the quotient of leg B, which is resolved one bit per stage over 18
// stages, plus three stages before it (ratio clamp, law multiply, saturation
// check) and three after (alpha scaling, compare multiply, output register).
// Configuration is written through cfg_we, cfg_index and cfg_wdata and
// should only change while no transaction is in flight.
module buck_boost_duty_law_top
    #(
        parameter int MAX_PHASES    = bbdl_pkg::MAX_PHASES_DEF,
        parameter int SYMMETRIC_PWM = bbdl_pkg::SYMMETRIC_PWM_DEF
    )
    (
        input  logic                      clk,
        input  logic                      rst_n,
        input  logic                      start,
        input  bbdl_pkg::duty_req_t       req,
        output logic                      busy,
        output logic                      done,
        output bbdl_pkg::duty_rsp_t       rsp,
        input  logic                      cfg_we,
        input  logic [bbdl_pkg::CFG_IDX_W-1:0] cfg_index,
        input  logic [bbdl_pkg::DUTY_W-1:0]    cfg_wdata
    );
    import bbdl_pkg::*;

    localparam logic [3:0] MAX_CNT = 4'(MAX_PHASES);

    logic [1:0]        law_mode_reg;
    logic [DUTY_W-1:0] duty_base_reg;
    logic [DUTY_W-1:0] mixed_gain_reg;
    logic [DUTY_W-1:0] ratio_floor_reg;
    logic [DUTY_W-1:0] ratio_ceiling_reg;
    logic [DUTY_W-1:0] duty_limit_reg;
    logic [DUTY_W-1:0] period_ticks_reg;
    logic [3:0]        phases_active_reg;

    pipe_t s1_reg, s1_next;
    pipe_t s2_reg, s2_next;
    pipe_t div_reg [DIV_STAGES+1];
    pipe_t div_next [DIV_STAGES+1];
    pipe_t sc_reg, sc_next;
    pipe_t cm_reg, cm_next;
    logic      done_reg;
    duty_rsp_t rsp_reg, rsp_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            law_mode_reg      <= RST_LAW_MODE;
            duty_base_reg     <= RST_DUTY_BASE;
            mixed_gain_reg    <= RST_MIXED_GAIN;
            ratio_floor_reg   <= RST_RATIO_FLOOR;
            ratio_ceiling_reg <= RST_RATIO_CEILING;
            duty_limit_reg    <= RST_DUTY_LIMIT;
            period_ticks_reg  <= RST_PERIOD_TICKS;
            phases_active_reg <= RST_PHASES_ACTIVE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LAW_MODE:      law_mode_reg      <= cfg_wdata[1:0];
                REG_DUTY_BASE:     duty_base_reg     <= cfg_wdata;
                REG_MIXED_GAIN:    mixed_gain_reg    <= cfg_wdata;
                REG_RATIO_FLOOR:   ratio_floor_reg   <= cfg_wdata;
                REG_RATIO_CEILING: ratio_ceiling_reg <= cfg_wdata;
                REG_DUTY_LIMIT:    duty_limit_reg    <= cfg_wdata;
                REG_PERIOD_TICKS:  period_ticks_reg  <= cfg_wdata;
                REG_PHASES_ACTIVE: phases_active_reg <= cfg_wdata[3:0];
                default:           law_mode_reg      <= law_mode_reg;
            endcase
        end
    end

    // stage 1: phase check and ratio clamp
    always_comb
    begin
        logic [3:0]        cnt;
        logic [DUTY_W-1:0] lo;
        s1_next        = '0;
        s1_next.valid  = start;
        s1_next.op     = req.opcode;
        s1_next.phase  = req.phase_index;
        s1_next.alpha  = req.alpha;
        s1_next.direct = req.direct_duty;
        cnt = (phases_active_reg == 4'd0) ? 4'd1 : phases_active_reg;
        if (cnt > MAX_CNT)
        begin
            cnt = MAX_CNT;
        end
        s1_next.acc = ({1'b0, req.phase_index} < cnt);
        lo = (ratio_floor_reg == '0) ? DUTY_W'(1) : ratio_floor_reg;
        if (req.ratio < lo)
        begin
            s1_next.r = lo;
        end
        else if (req.ratio > ratio_ceiling_reg)
        begin
            s1_next.r = ratio_ceiling_reg;
        end
        else
        begin
            s1_next.r = req.ratio;
        end
    end

    // stage 2: law multiply, leg A law duty and leg B dividend
    always_comb
    begin
        logic [16:0]       mul_a;
        logic [DUTY_W-1:0] coef;
        logic [NUM_W-1:0]  prod;
        logic [NUM_W-14-1:0] shr;
        s2_next = s1_reg;
        mul_a = (law_mode_reg == MODE_BUCK) ? {1'b0, s1_reg.r} : ({1'b0, s1_reg.r} + Q14_ONE);
        coef  = (law_mode_reg == MODE_BUCK || law_mode_reg == MODE_BOOST) ?
                duty_base_reg : mixed_gain_reg;
        prod  = NUM_W'(coef) * NUM_W'(mul_a);
        shr   = prod[NUM_W-1:14];
        s2_next.lb_base = 1'b0;
        case (law_mode_reg)
            MODE_BUCK:
            begin
                s2_next.la      = LAW_W'(shr);
                s2_next.lb_base = 1'b1;
                s2_next.num     = '0;
            end
            MODE_BOOST:
            begin
                s2_next.la  = LAW_W'(duty_base_reg);
                s2_next.num = {3'b000, duty_base_reg, 14'd0};
            end
            default:
            begin
                s2_next.la  = (shr > (NUM_W-14)'(LAW_SAT)) ? LAW_SAT : LAW_W'(shr);
                s2_next.num = prod;
            end
        endcase
    end

    // stage 3: quotient overflow check, divider seed
    always_comb
    begin
        div_next[0]        = s2_reg;
        div_next[0].lb_sat = ({1'b0, s2_reg.num} >= {s2_reg.r, LAW_W'(0)});
        div_next[0].rem    = {1'b0, s2_reg.num[NUM_W-1:LAW_W]};
        div_next[0].quo    = '0;
    end

    // divider stages: one quotient bit each
    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_div
        always_comb
        begin
            logic [DUTY_W:0] trial;
            div_next[k] = div_reg[k-1];
            trial = {div_reg[k-1].rem, div_reg[k-1].num[DIV_STAGES-k]};
            if (trial >= {1'b0, div_reg[k-1].r})
            begin
                div_next[k].rem = DUTY_W'(trial - {1'b0, div_reg[k-1].r});
                div_next[k].quo = {div_reg[k-1].quo[LAW_W-2:0], 1'b1};
            end
            else
            begin
                div_next[k].rem = trial[DUTY_W-1:0];
                div_next[k].quo = {div_reg[k-1].quo[LAW_W-2:0], 1'b0};
            end
        end
    end

    // alpha scaling and duty limit
    always_comb
    begin
        pipe_t             p;
        logic [LAW_W-1:0]  lb;
        logic [LAW_W+DUTY_W-1:0] pa, pb;
        logic [LAW_W+DUTY_W-15:0] ta, tb;
        p = div_reg[DIV_STAGES];
        sc_next = p;
        if (p.lb_base)
        begin
            lb = LAW_W'(duty_base_reg);
        end
        else if (p.lb_sat)
        begin
            lb = LAW_SAT;
        end
        else
        begin
            lb = p.quo;
        end
        pa = (LAW_W+DUTY_W)'(p.la) * (LAW_W+DUTY_W)'(p.alpha);
        pb = (LAW_W+DUTY_W)'(lb) * (LAW_W+DUTY_W)'(p.alpha);
        ta = pa[LAW_W+DUTY_W-1:14];
        tb = pb[LAW_W+DUTY_W-1:14];
        if (p.op == OP_DIRECT)
        begin
            sc_next.da = (p.direct > duty_limit_reg) ? duty_limit_reg : p.direct;
            sc_next.db = '0;
        end
        else
        begin
            sc_next.da = (ta > (LAW_W+DUTY_W-14)'(duty_limit_reg)) ?
                         duty_limit_reg : DUTY_W'(ta);
            sc_next.db = (tb > (LAW_W+DUTY_W-14)'(duty_limit_reg)) ?
                         duty_limit_reg : DUTY_W'(tb);
        end
    end

    // timer compare values
    always_comb
    begin
        logic [14:0] half;
        logic [32:0] m0, m1, m2, m3;
        cm_next = sc_reg;
        half = period_ticks_reg[DUTY_W-1:1];
        if (SYMMETRIC_PWM != 0)
        begin
            m0 = 33'(half) * (33'd65536 - 33'(sc_reg.da));
            m1 = 33'(half) * (33'd65536 + 33'(sc_reg.da));
            m2 = 33'(half) * (33'd65536 - 33'(sc_reg.db));
            m3 = 33'(half) * (33'd65536 + 33'(sc_reg.db));
        end
        else
        begin
            m0 = 33'(period_ticks_reg) * 33'(sc_reg.da);
            m1 = '0;
            m2 = 33'(period_ticks_reg) * 33'(sc_reg.db);
            m3 = '0;
        end
        cm_next.rise_a = m0[31:16];
        cm_next.fall_a = m1[31:16];
        cm_next.rise_b = m2[31:16];
        cm_next.fall_b = m3[31:16];
    end

    // result fields, zeroed for rejected transactions; leg B fields zeroed for direct ones
    always_comb
    begin
        logic law;
        rsp_next           = '0;
        rsp_next.phase_out = cm_reg.phase;
        law = cm_reg.acc && (cm_reg.op == OP_LAW);
        if (cm_reg.acc)
        begin
            rsp_next.accepted   = 1'b1;
            rsp_next.duty_leg_a = cm_reg.da;
            rsp_next.rise_cmp_a = cm_reg.rise_a;
            rsp_next.fall_cmp_a = cm_reg.fall_a;
        end
        if (law)
        begin
            rsp_next.duty_leg_b    = cm_reg.db;
            rsp_next.rise_cmp_b    = cm_reg.rise_b;
            rsp_next.fall_cmp_b    = cm_reg.fall_b;
            rsp_next.leg_b_updated = 1'b1;
            rsp_next.clamped_ratio = cm_reg.r;
        end
    end

    // pipeline registers, cleared on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            sc_reg   <= '0;
            cm_reg   <= '0;
            done_reg <= 1'b0;
            rsp_reg  <= '0;
        end
        else
        begin
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
            sc_reg   <= sc_next;
            cm_reg   <= cm_next;
            done_reg <= cm_reg.valid;
            rsp_reg  <= rsp_next;
        end
    end

    for (genvar k = 0; k <= DIV_STAGES; k++)
    begin : g_div_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_reg[k] <= '0;
            end
            else
            begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

### design/bbdl_checker.sv
// port-level checker for the duty law block and its bind
`include "buck_boost_duty_law_top_macros.svh"

module bbdl_checker
    (
        input logic                clk,
        input logic                rst_n,
        input logic                start,
        input bbdl_pkg::duty_req_t req,
        input logic                busy,
        input logic                done,
        input bbdl_pkg::duty_rsp_t rsp
    );
    import bbdl_pkg::*;

    logic rejected_clean;

    assign rejected_clean = rsp.accepted ||
        (rsp.duty_leg_a == '0 && rsp.duty_leg_b == '0 && rsp.rise_cmp_a == '0 &&
         rsp.fall_cmp_a == '0 && rsp.rise_cmp_b == '0 && rsp.fall_cmp_b == '0 &&
         !rsp.leg_b_updated && rsp.clamped_ratio == '0);

    // a result appears exactly once for each transaction and never otherwise
    `BBDL_ASSERT_IMPLY(a_latency, clk, rst_n, $past(rst_n, PIPE_LATENCY), (done == ($past(start, PIPE_LATENCY) && !$past(busy, PIPE_LATENCY))))
    // the phase of a result is that of its transaction
    `BBDL_ASSERT_IMPLY(a_phase, clk, rst_n, done && $past(rst_n, PIPE_LATENCY), (rsp.phase_out == $past(req.phase_index, PIPE_LATENCY)))
    // rejected results carry nothing but the phase
    `BBDL_ASSERT_IMPLY(a_reject, clk, rst_n, done, rejected_clean)
    // leg b is only reported for accepted transactions
    `BBDL_ASSERT_NEVER(a_legb, clk, rst_n, done && rsp.leg_b_updated && !rsp.accepted)

endmodule

bind buck_boost_duty_law_top bbdl_checker u_bbdl_checker
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

### dv/buck_boost_duty_law_top_tb.sv
// self-checking testbench for the buck-boost duty law pipeline
`timescale 1ns / 100ps

module buck_boost_duty_law_top_tb;
    import bbdl_pkg::*;

    localparam int LATENCY  = PIPE_LATENCY;
    localparam int N_RANDOM = 600;

    logic clk;
    logic rst_n;
    logic start;
    duty_req_t req;
    logic busy;
    logic done;
    duty_rsp_t rsp;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DUTY_W-1:0] cfg_wdata;

    // local copy of the configuration
    logic [1:0] law_mode_q;
    logic [15:0] duty_base_q;
    logic [15:0] mixed_gain_q;
    logic [15:0] ratio_floor_q;
    logic [15:0] ratio_ceiling_q;
    logic [15:0] duty_limit_q;
    logic [15:0] period_ticks_q;
    logic [3:0] phases_active_q;

    duty_rsp_t pending_duties[$];
    int errors;
    int n_sent;
    int n_seen;

    buck_boost_duty_law_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // run limit
    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // timer compares of one leg
    function automatic void leg_compare(input logic [15:0] d, output logic [15:0] rise,
                                        output logic [15:0] fall);
        logic [63:0] half;
        begin
            half = {48'd0, period_ticks_q} >> 1;
            if (SYMMETRIC_PWM_DEF != 0)
            begin
                rise = 16'((half * (64'd65536 - d)) >> 16);
                fall = 16'((half * (64'd65536 + d)) >> 16);
            end
            else
            begin
                rise = 16'(({48'd0, period_ticks_q} * d) >> 16);
                fall = 16'd0;
            end
        end
    endfunction

    // alpha scaling and limit of one law duty
    function automatic logic [15:0] scaled_duty(input logic [63:0] law, input logic [15:0] alpha);
        logic [63:0] d;
        begin
            if (law > 64'd262143)
                law = 64'd262143;
            d = (law * alpha) >> 14;
            scaled_duty = (d > duty_limit_q) ? duty_limit_q : d[15:0];
        end
    endfunction

    // expected duty update for one request
    function automatic duty_rsp_t predict_duty(input duty_req_t q);
        duty_rsp_t e;
        logic [63:0] cnt, lo, r, la, lb;
        begin
            e = '0;
            e.phase_out = q.phase_index;
            cnt = phases_active_q;
            if (cnt == 0)
                cnt = 1;
            if (cnt > MAX_PHASES_DEF)
                cnt = MAX_PHASES_DEF;
            if (q.phase_index < cnt)
            begin
                e.accepted = 1'b1;
                if (q.opcode == OP_DIRECT)
                begin
                    e.duty_leg_a = (q.direct_duty > duty_limit_q) ? duty_limit_q : q.direct_duty;
                    leg_compare(e.duty_leg_a, e.rise_cmp_a, e.fall_cmp_a);
                end
                else
                begin
                    lo = (ratio_floor_q == 0) ? 1 : ratio_floor_q;
                    r = q.ratio;
                    if (r < lo)
                        r = lo;
                    else if (r > ratio_ceiling_q)
                        r = ratio_ceiling_q;
                    if (law_mode_q == MODE_BUCK)
                    begin
                        la = (duty_base_q * r) >> 14;
                        lb = duty_base_q;
                    end
                    else if (law_mode_q == MODE_BOOST)
                    begin
                        la = duty_base_q;
                        lb = ({48'd0, duty_base_q} << 14) / r;
                    end
                    else
                    begin
                        la = (mixed_gain_q * (r + 64'd16384)) >> 14;
                        lb = (mixed_gain_q * (r + 64'd16384)) / r;
                    end
                    e.duty_leg_a = scaled_duty(la, q.alpha);
                    e.duty_leg_b = scaled_duty(lb, q.alpha);
                    leg_compare(e.duty_leg_a, e.rise_cmp_a, e.fall_cmp_a);
                    leg_compare(e.duty_leg_b, e.rise_cmp_b, e.fall_cmp_b);
                    e.leg_b_updated = 1'b1;
                    e.clamped_ratio = r[15:0];
                end
            end
            predict_duty = e;
        end
    endfunction

    // register write, mirrored locally
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= val;
            @(posedge clk);
            cfg_we <= 1'b0;
            @(posedge clk);
            case (idx)
                REG_LAW_MODE:      law_mode_q = val[1:0];
                REG_DUTY_BASE:     duty_base_q = val;
                REG_MIXED_GAIN:    mixed_gain_q = val;
                REG_RATIO_FLOOR:   ratio_floor_q = val;
                REG_RATIO_CEILING: ratio_ceiling_q = val;
                REG_DUTY_LIMIT:    duty_limit_q = val;
                REG_PERIOD_TICKS:  period_ticks_q = val;
                REG_PHASES_ACTIVE: phases_active_q = val[3:0];
                default:           ;
            endcase
        end
    endtask

    // wait until the pipeline has drained
    task automatic drain;
        int guard;
        begin
            start <= 1'b0;
            guard = 0;
            while (pending_duties.size() != 0 && guard < 100000)
            begin
                @(posedge clk);
                guard++;
            end
            repeat (LATENCY + 4) @(posedge clk);
        end
    endtask

    // idle gap in the sender
    task automatic idle_gap(input int n);
        begin
            if (n > 0)
            begin
                start <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    endtask

    // issue one transaction; expectation is queued at acceptance
    task automatic send_duty(input duty_req_t q, input bit has_fixed, input duty_rsp_t fixed);
        begin
            start <= 1'b1;
            req <= q;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            pending_duties.push_back(has_fixed ? fixed : predict_duty(q));
            n_sent++;
        end
    endtask

    // random request, mostly accepted phases
    function automatic duty_req_t rand_req;
        duty_req_t q;
        begin
            q.opcode = ($urandom_range(0, 3) == 0) ? OP_DIRECT : OP_LAW;
            q.phase_index = ($urandom_range(0, 4) == 0) ? 3'($urandom)
                          : 3'($urandom_range(0, (phases_active_q > 8 || phases_active_q == 0)
                                              ? 0 : phases_active_q - 1));
            case ($urandom_range(0, 3))
                0: q.ratio = 16'($urandom);
                1: q.ratio = 16'($urandom_range(ratio_floor_q, 16'hffff));
                default: q.ratio = 16'($urandom_range(8000, 40000));
            endcase
            q.alpha = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(8000, 24000));
            q.direct_duty = 16'($urandom);
            rand_req = q;
        end
    endfunction

    // random phase of traffic in bursts with gaps
    task automatic random_burst(input int n);
        int burst;
        begin
            burst = 0;
            for (int i = 0; i < n; i++)
            begin
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 20);
                    idle_gap($urandom_range(0, 6));
                end
                send_duty(rand_req(), 1'b0, '0);
                burst--;
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        duty_rsp_t e;
        if (rst_n && done)
        begin
            n_seen++;
            if (pending_duties.size() == 0)
            begin
                $display("%0t: unexpected transaction %h", $time, rsp);
                errors++;
            end
            else
            begin
                e = pending_duties.pop_front();
                if (rsp !== e)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, rsp);
                    if (rsp.duty_leg_a !== e.duty_leg_a || rsp.duty_leg_b !== e.duty_leg_b)
                        $display("%0t: duties expected %0d/%0d actual %0d/%0d", $time,
                                 e.duty_leg_a, e.duty_leg_b, rsp.duty_leg_a, rsp.duty_leg_b);
                    errors++;
                end
            end
        end
    end

    typedef struct {
        duty_req_t q;
        bit        fixed;
        duty_rsp_t r;
    } dir_row_t;

    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        int guard;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        errors = 0;
        n_sent = 0;
        n_seen = 0;
        law_mode_q = RST_LAW_MODE;
        duty_base_q = RST_DUTY_BASE;
        mixed_gain_q = RST_MIXED_GAIN;
        ratio_floor_q = RST_RATIO_FLOOR;
        ratio_ceiling_q = RST_RATIO_CEILING;
        duty_limit_q = RST_DUTY_LIMIT;
        period_ticks_q = RST_PERIOD_TICKS;
        phases_active_q = RST_PHASES_ACTIVE;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at reset settings: rejected phases, direct extremes, law extremes
        rows.push_back('{'{OP_LAW, 3'd7, 16'd0, 16'd0, 16'd0}, 1,
                         '{3'd7, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0}});
        rows.push_back('{'{OP_DIRECT, 3'd1, 16'hffff, 16'hffff, 16'hffff}, 1,
                         '{3'd1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0}});
        rows.push_back('{'{OP_DIRECT, 3'd0, 16'd0, 16'd0, 16'hffff}, 1,
                         '{3'd0, 1'b1, RST_DUTY_LIMIT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                           1'b0, 16'd0}});
        rows.push_back('{'{OP_DIRECT, 3'd0, 16'hffff, 16'hffff, 16'd0}, 1,
                         '{3'd0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0}});
        rows.push_back('{'{OP_LAW, 3'd0, 16'd0, 16'd16384, 16'd0}, 0, '0});
        rows.push_back('{'{OP_LAW, 3'd0, 16'hffff, 16'hffff, 16'hffff}, 0, '0});
        rows.push_back('{'{OP_LAW, 3'd0, 16'd16384, 16'd0, 16'd0}, 0, '0});
        foreach (rows[i])
            send_duty(rows[i].q, rows[i].fixed, rows[i].r);
        drain();

        // extremes: floor zero, floor above ceiling, all modes
        write_reg(REG_PHASES_ACTIVE, 16'd0);
        write_reg(REG_PERIOD_TICKS, 16'hffff);
        write_reg(REG_RATIO_FLOOR, 16'd0);
        write_reg(REG_RATIO_CEILING, 16'hffff);
        write_reg(REG_DUTY_LIMIT, 16'hffff);
        write_reg(REG_DUTY_BASE, 16'hffff);
        write_reg(REG_MIXED_GAIN, 16'hffff);
        for (int m = 0; m < 4; m++)
        begin
            write_reg(REG_LAW_MODE, 16'(m));
            rows.delete();
            row.fixed = 0;
            row.r = '0;
            row.q = '{OP_LAW, 3'd0, 16'd0, 16'hffff, 16'd0};
            send_duty(row.q, 0, '0);
            row.q = '{OP_LAW, 3'd0, 16'hffff, 16'hffff, 16'hffff};
            send_duty(row.q, 0, '0);
            row.q = '{OP_DIRECT, 3'd0, 16'hffff, 16'd0, 16'h8000};
            send_duty(row.q, 0, '0);
            row.q = '{OP_LAW, 3'd1, 16'd1, 16'd1, 16'd1};
            send_duty(row.q, 0, '0);
            drain();
        end
        write_reg(REG_RATIO_FLOOR, 16'd30000);
        write_reg(REG_RATIO_CEILING, 16'd10000);
        write_reg(REG_PHASES_ACTIVE, 16'd15);
        write_reg(REG_DUTY_LIMIT, 16'd0);
        send_duty('{OP_LAW, 3'd7, 16'd20000, 16'd16384, 16'd0}, 0, '0);
        send_duty('{OP_LAW, 3'd5, 16'd40000, 16'd16384, 16'd0}, 0, '0);
        send_duty('{OP_LAW, 3'd6, 16'd5000, 16'hffff, 16'd0}, 0, '0);
        drain();

        // random phases under several settings
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_LAW_MODE, 16'($urandom_range(0, 3)));
            write_reg(REG_DUTY_BASE, (p == 0) ? 16'd0 : 16'($urandom));
            write_reg(REG_MIXED_GAIN, 16'($urandom));
            write_reg(REG_RATIO_FLOOR, 16'($urandom_range(1, 20000)));
            write_reg(REG_RATIO_CEILING, 16'($urandom_range(10000, 65535)));
            write_reg(REG_DUTY_LIMIT, (p == 1) ? 16'hffff : 16'($urandom));
            write_reg(REG_PERIOD_TICKS, (p == 2) ? 16'd0 : 16'($urandom));
            write_reg(REG_PHASES_ACTIVE, 16'($urandom_range(0, 15)));
            random_burst(N_RANDOM / 6);
            // sender pauses until everything is back
            if (p == 3)
            begin
                start <= 1'b0;
                @(posedge clk);
                guard = 0;
                while (pending_duties.size() != 0 && guard < 10000)
                begin
                    @(posedge clk);
                    guard++;
                end
                random_burst(20);
            end
            drain();
        end

        $display("covered %0d transactions over all law modes, direct duties and rejected phases",
                 n_sent);
        $display("%0d results checked, %0d mismatches", n_seen, errors);
        if (errors == 0 && pending_duties.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
